// ===== hdl/hss_pkg.sv =====
// Shared types and constants of the hair strand shader.
// Used by hair_strand_shader; depends on nothing.
`default_nettype none
package hss_pkg;

    localparam int POS_WIDTH_DEF = 24;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int TAN_W         = 16;
    localparam int MAG_W         = 25;
    localparam int SUMSQ_W       = 52;
    localparam int LEN_W         = SUMSQ_W / 2;
    localparam int QUO_W         = 15;
    localparam int DIR_W         = 16;
    localparam int COS_W         = 20;
    localparam int SIN_ARG_W     = 34;
    localparam int SIN_W         = SIN_ARG_W / 2;
    localparam int FRAC_BITS     = 8;
    localparam int INT_BITS      = 8;
    localparam int SHADE_W       = 17;
    localparam int OUT_DATA_W    = 56;

    localparam logic [QUO_W-1:0]   ONE_Q14 = 15'd16384;
    localparam logic [SIN_W-1:0]   ONE_Q16 = 17'd65536;
    localparam logic [SHADE_W-1:0] OUT_MAX = 17'd131071;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DIFFUSE_RED   = 3'd0,
        CFG_DIFFUSE_GREEN = 3'd1,
        CFG_DIFFUSE_BLUE  = 3'd2,
        CFG_LIGHT_RED     = 3'd3,
        CFG_LIGHT_GREEN   = 3'd4,
        CFG_LIGHT_BLUE    = 3'd5,
        CFG_SHININESS     = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [5:0][MAG_W-1:0] mag;
        logic [5:0]            neg;
        logic [2:0][TAN_W-1:0] tan;
    } norm_side_t;

    typedef struct packed {
        logic [5:0]            neg;
        logic [2:0][TAN_W-1:0] tan;
    } div_side_t;

    typedef struct packed {
        logic [1:0][COS_W-1:0] cosv;
    } sin_side_t;

    typedef struct packed {
        logic [SIN_W-1:0] res;
        logic [SIN_W-1:0] stl;
    } root_side_t;

endpackage
`default_nettype wire

// ===== hdl/hss_isqrt.sv =====
// Pipelined floor square root, one result bit per stage, several lanes.
// Carries a sideband word alongside; no package dependency.
`default_nettype none
module hss_isqrt #(
    parameter int AW    = 34,
    parameter int LANES = 1,
    parameter int SW    = 1
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [LANES-1:0][AW-1:0]    in_arg,
    input  wire logic [SW-1:0]               in_side,
    output logic                             out_valid,
    output logic [LANES-1:0][AW/2-1:0]       out_root,
    output logic [SW-1:0]                    out_side
);
    localparam int RW = AW / 2;
    localparam int XW = RW + 2;

    logic                       vld_reg  [RW];
    logic [LANES-1:0][RW-1:0]   root_reg [RW];
    logic [SW-1:0]              side_reg [RW];
    logic [LANES-1:0][XW-1:0]   rem_reg  [RW-1];
    logic [LANES-1:0][AW-1:0]   arg_reg  [RW-1];

    for (genvar i = 0; i < RW; i++) begin : g_step
        logic                     prev_vld;
        logic [LANES-1:0][RW-1:0] prev_root;
        logic [LANES-1:0][XW-1:0] prev_rem;
        logic [LANES-1:0][AW-1:0] prev_arg;
        logic [SW-1:0]            prev_side;
        logic [LANES-1:0][XW-1:0] rem_next;
        logic [LANES-1:0][RW-1:0] root_next;
        logic [LANES-1:0][AW-1:0] arg_next;

        if (i == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_root = '0;
            assign prev_rem  = '0;
            assign prev_arg  = in_arg;
            assign prev_side = in_side;
        end else begin : g_rest
            assign prev_vld  = vld_reg[i-1];
            assign prev_root = root_reg[i-1];
            assign prev_rem  = rem_reg[i-1];
            assign prev_arg  = arg_reg[i-1];
            assign prev_side = side_reg[i-1];
        end

        always_comb begin
            logic [XW-1:0] shifted;
            logic [XW-1:0] trial;
            for (int l = 0; l < LANES; l++) begin
                shifted = {prev_rem[l][RW-1:0], prev_arg[l][AW-1:AW-2]};
                trial   = {prev_root[l], 2'b01};
                if (shifted >= trial) begin
                    rem_next[l]  = shifted - trial;
                    root_next[l] = {prev_root[l][RW-2:0], 1'b1};
                end else begin
                    rem_next[l]  = shifted;
                    root_next[l] = {prev_root[l][RW-2:0], 1'b0};
                end
                arg_next[l] = {prev_arg[l][AW-3:0], 2'b00};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[i] <= root_next;
                side_reg[i] <= prev_side;
            end
        end

        if (i < RW - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    arg_reg[i] <= arg_next;
                end
            end
        end
    end

    assign out_valid = vld_reg[RW-1];
    assign out_root  = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule
`default_nettype wire

// ===== hdl/hss_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Computes (num << (QW-1)) / den for num <= den, zero for den == 0; no package use.
`default_nettype none
module hss_div #(
    parameter int LANES = 6,
    parameter int NW    = 25,
    parameter int DW    = 26,
    parameter int QW    = 15,
    parameter int SW    = 1
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      en,
    input  wire logic                      in_valid,
    input  wire logic [LANES-1:0][NW-1:0]  in_num,
    input  wire logic [LANES-1:0][DW-1:0]  in_den,
    input  wire logic [SW-1:0]             in_side,
    output logic                           out_valid,
    output logic [LANES-1:0][QW-1:0]       out_quo,
    output logic [SW-1:0]                  out_side
);
    localparam int XW = DW + 1;

    logic                      vld_reg  [QW];
    logic [LANES-1:0][QW-1:0]  quo_reg  [QW];
    logic [SW-1:0]             side_reg [QW];
    logic [LANES-1:0][XW-1:0]  rem_reg  [QW-1];
    logic [LANES-1:0][DW-1:0]  den_reg  [QW-1];

    for (genvar i = 0; i < QW; i++) begin : g_step
        logic                     prev_vld;
        logic [LANES-1:0][QW-1:0] prev_quo;
        logic [LANES-1:0][DW-1:0] prev_den;
        logic [SW-1:0]            prev_side;
        logic [LANES-1:0][XW-1:0] shifted;
        logic [LANES-1:0][XW-1:0] rem_next;
        logic [LANES-1:0][QW-1:0] quo_next;

        if (i == 0) begin : g_first
            assign prev_vld  = in_valid;
            assign prev_quo  = '0;
            assign prev_den  = in_den;
            assign prev_side = in_side;
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    shifted[l] = XW'(in_num[l]);
                end
            end
        end else begin : g_rest
            assign prev_vld  = vld_reg[i-1];
            assign prev_quo  = quo_reg[i-1];
            assign prev_den  = den_reg[i-1];
            assign prev_side = side_reg[i-1];
            always_comb begin
                for (int l = 0; l < LANES; l++) begin
                    shifted[l] = {rem_reg[i-1][l][DW-1:0], 1'b0};
                end
            end
        end

        always_comb begin
            logic ge;
            for (int l = 0; l < LANES; l++) begin
                ge = (prev_den[l] != '0) && (shifted[l] >= {1'b0, prev_den[l]});
                rem_next[l] = ge ? shifted[l] - {1'b0, prev_den[l]} : shifted[l];
                quo_next[l] = {prev_quo[l][QW-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= prev_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                quo_reg[i]  <= quo_next;
                side_reg[i] <= prev_side;
            end
        end

        if (i < QW - 1) begin : g_keep
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[i] <= rem_next;
                    den_reg[i] <= prev_den;
                end
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign out_quo   = quo_reg[QW-1];
    assign out_side  = side_reg[QW-1];

endmodule
`default_nettype wire

// ===== hdl/hair_strand_shader.sv =====
// Hair strand shader top level: fixed-point hair shading over a hit stream.
// Depends on hss_pkg, hss_isqrt and hss_div.
//
// Usage:
//   s_tdata carries one hit request: hit, lamp and view positions and the strand
//   tangent. m_tdata returns the shaded red, green and blue values, saturated.
//   cfg_wr_en/cfg_wr_addr/cfg_wr_data write the colour, light and shininess
//   registers; write only while no request is in flight. Unknown indexes drop.
// Throughput: one request per cycle while not stalled, no dependence between requests.
// Pipeline: the same depth at POS_WIDTH of any value. It includes the stage
//   chains of the square root units (26 stages for the direction lengths, 17
//   for the sines, 8 x 17 for the fractional exponent roots), the 15-stage
//   divider and the 8 integer exponent stages.
// Reset: aresetn low clears every valid bit and loads the register defaults.
// Stall: while m_tvalid is high and m_tready low, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
`default_nettype none
module hair_strand_shader #(
    parameter int POS_WIDTH = hss_pkg::POS_WIDTH_DEF
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // hit_x/y/z, lamp_x/y/z, view_x/y/z (POS_WIDTH each), strand_x/y/z (16 each)
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [((9*POS_WIDTH+48+7)/8)*8-1:0] s_tdata,
    // shade_red, shade_green, shade_blue (17 each), zero fill
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [hss_pkg::OUT_DATA_W-1:0]           m_tdata,
    input  wire logic                                cfg_wr_en,
    input  wire logic [hss_pkg::CFG_ADDR_W-1:0]      cfg_wr_addr,
    input  wire logic [hss_pkg::CFG_W-1:0]           cfg_wr_data
);
    import hss_pkg::*;

    localparam int PW  = POS_WIDTH;
    localparam int MXW = (PW > MAG_W) ? PW : MAG_W;
    localparam int NPW = INT_BITS + FRAC_BITS;

    logic en;

    // configuration
    logic [CFG_W-1:0] diffuse_reg [3];
    logic [CFG_W-1:0] light_reg   [3];
    logic [CFG_W-1:0] shiny_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int c = 0; c < 3; c++) begin
                diffuse_reg[c] <= 16'd32768;
                light_reg[c]   <= 16'd4096;
            end
            shiny_reg <= 16'd12800;
        end else if (cfg_wr_en) begin
            case (cfg_idx_t'(cfg_wr_addr))
                CFG_DIFFUSE_RED:   diffuse_reg[0] <= cfg_wr_data;
                CFG_DIFFUSE_GREEN: diffuse_reg[1] <= cfg_wr_data;
                CFG_DIFFUSE_BLUE:  diffuse_reg[2] <= cfg_wr_data;
                CFG_LIGHT_RED:     light_reg[0]   <= cfg_wr_data;
                CFG_LIGHT_GREEN:   light_reg[1]   <= cfg_wr_data;
                CFG_LIGHT_BLUE:    light_reg[2]   <= cfg_wr_data;
                CFG_SHININESS:     shiny_reg      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // stage 1: direction differences as sign and magnitude
    logic                s1_vld_reg;
    logic [PW-1:0]       s1_mag_reg [6];
    logic [5:0]          s1_neg_reg;
    logic [2:0][TAN_W-1:0] s1_tan_reg;
    logic [PW-1:0]       s1_mag_next [6];
    logic [5:0]          s1_neg_next;

    always_comb begin
        logic [PW:0] d;
        logic [PW:0] hit, lamp, view;
        for (int c = 0; c < 3; c++) begin
            hit  = {s_tdata[c*PW + PW - 1], s_tdata[c*PW +: PW]};
            lamp = {s_tdata[(3+c)*PW + PW - 1], s_tdata[(3+c)*PW +: PW]};
            view = {s_tdata[(6+c)*PW + PW - 1], s_tdata[(6+c)*PW +: PW]};
            d = lamp - hit;
            s1_neg_next[c] = d[PW];
            s1_mag_next[c] = d[PW] ? PW'(-d) : d[PW-1:0];
            d = hit - view;
            s1_neg_next[3+c] = d[PW];
            s1_mag_next[3+c] = d[PW] ? PW'(-d) : d[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_mag_reg <= s1_mag_next;
            s1_neg_reg <= s1_neg_next;
            for (int c = 0; c < 3; c++) begin
                s1_tan_reg[c] <= s_tdata[9*PW + c*TAN_W +: TAN_W];
            end
        end
    end

    // stage 2: right shift, common to the three components of each direction, until its largest magnitude fits
    logic       s2_vld_reg;
    norm_side_t s2_side_reg;
    norm_side_t s2_side_next;

    always_comb begin
        logic [PW-1:0]  mx;
        logic [2:0]     sh;
        logic [MXW-1:0] wide;
        s2_side_next.neg = s1_neg_reg;
        s2_side_next.tan = s1_tan_reg;
        for (int g = 0; g < 2; g++) begin
            mx = s1_mag_reg[3*g];
            if (s1_mag_reg[3*g+1] > mx) mx = s1_mag_reg[3*g+1];
            if (s1_mag_reg[3*g+2] > mx) mx = s1_mag_reg[3*g+2];
            sh = '0;
            for (int i = MAG_W; i < PW; i++) begin
                if (mx[i]) sh = 3'(i - MAG_W + 1);
            end
            for (int c = 0; c < 3; c++) begin
                wide = MXW'(s1_mag_reg[3*g+c]) >> sh;
                s2_side_next.mag[3*g+c] = wide[MAG_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_vld_reg <= 1'b0;
        end else if (en) begin
            s2_vld_reg <= s1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) s2_side_reg <= s2_side_next;
    end

    // stage 3: squares; stage 4: sums of squares
    logic                  s3_vld_reg;
    norm_side_t            s3_side_reg;
    logic [2*MAG_W-1:0]    s3_sq_reg [6];
    logic                  s4_vld_reg;
    norm_side_t            s4_side_reg;
    logic [1:0][SUMSQ_W-1:0] s4_sum_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end else if (en) begin
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_side_reg <= s2_side_reg;
            for (int l = 0; l < 6; l++) begin
                s3_sq_reg[l] <= (2*MAG_W)'(s2_side_reg.mag[l]) * (2*MAG_W)'(s2_side_reg.mag[l]);
            end
            s4_side_reg <= s3_side_reg;
            for (int g = 0; g < 2; g++) begin
                s4_sum_reg[g] <= SUMSQ_W'(s3_sq_reg[3*g]) + SUMSQ_W'(s3_sq_reg[3*g+1])
                               + SUMSQ_W'(s3_sq_reg[3*g+2]);
            end
        end
    end

    // direction lengths
    logic                  len_vld;
    logic [1:0][LEN_W-1:0] len_root;
    logic [$bits(norm_side_t)-1:0] len_side_raw;
    norm_side_t            len_side;

    hss_isqrt #(
        .AW    (SUMSQ_W),
        .LANES (2),
        .SW    ($bits(norm_side_t))
    ) u_len_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s4_vld_reg),
        .in_arg    (s4_sum_reg),
        .in_side   (s4_side_reg),
        .out_valid (len_vld),
        .out_root  (len_root),
        .out_side  (len_side_raw)
    );

    assign len_side = norm_side_t'(len_side_raw);

    // normalize: component / length in Q1.14
    logic [5:0][MAG_W-1:0] div_num;
    logic [5:0][LEN_W-1:0] div_den;
    div_side_t             div_in_side;
    logic                  quo_vld;
    logic [5:0][QUO_W-1:0] quo;
    logic [$bits(div_side_t)-1:0] quo_side_raw;
    div_side_t             quo_side;

    always_comb begin
        for (int l = 0; l < 6; l++) begin
            div_num[l] = len_side.mag[l];
            div_den[l] = len_root[l / 3];
        end
        div_in_side.neg = len_side.neg;
        div_in_side.tan = len_side.tan;
    end

    hss_div #(
        .LANES (6),
        .NW    (MAG_W),
        .DW    (LEN_W),
        .QW    (QUO_W),
        .SW    ($bits(div_side_t))
    ) u_norm_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (len_vld),
        .in_num    (div_num),
        .in_den    (div_den),
        .in_side   (div_in_side),
        .out_valid (quo_vld),
        .out_quo   (quo),
        .out_side  (quo_side_raw)
    );

    assign quo_side = div_side_t'(quo_side_raw);

    // stage 5: signed unit vectors; 6: products; 7: dot; 8: cosines
    logic                        s5_vld_reg, s6_vld_reg, s7_vld_reg, s8_vld_reg;
    logic signed [DIR_W-1:0]     s5_u_reg [6];
    logic [2:0][TAN_W-1:0]       s5_tan_reg;
    logic signed [2*DIR_W-1:0]   s6_prod_reg [6];
    logic signed [2*DIR_W+1:0]   s7_dot_reg [2];
    logic [1:0][COS_W-1:0]       s8_cos_reg;
    logic [1:0][COS_W-1:0]       s8_cos_next;

    always_comb begin
        logic [2*DIR_W+1:0] amag;
        logic [COS_W-2:0]   cm;
        for (int g = 0; g < 2; g++) begin
            amag = s7_dot_reg[g][2*DIR_W+1] ? -s7_dot_reg[g] : s7_dot_reg[g];
            cm   = amag[COS_W+10:12];
            s8_cos_next[g] = s7_dot_reg[g][2*DIR_W+1] ? -{1'b0, cm} : {1'b0, cm};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            s8_vld_reg <= 1'b0;
        end else if (en) begin
            s5_vld_reg <= quo_vld;
            s6_vld_reg <= s5_vld_reg;
            s7_vld_reg <= s6_vld_reg;
            s8_vld_reg <= s7_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                s5_u_reg[l] <= quo_side.neg[l] ? -$signed({1'b0, quo[l]})
                                               : $signed({1'b0, quo[l]});
                s6_prod_reg[l] <= s5_u_reg[l] * $signed(s5_tan_reg[l % 3]);
            end
            s5_tan_reg <= quo_side.tan;
            for (int g = 0; g < 2; g++) begin
                s7_dot_reg[g] <= (2*DIR_W+2)'(s6_prod_reg[3*g])
                               + (2*DIR_W+2)'(s6_prod_reg[3*g+1])
                               + (2*DIR_W+2)'(s6_prod_reg[3*g+2]);
            end
            s8_cos_reg <= s8_cos_next;
        end
    end

    // stage 9: cosine squares; stage 10: sine root arguments
    logic                        s9_vld_reg, s10_vld_reg;
    logic [1:0][COS_W-1:0]       s9_cos_reg, s10_cos_reg;
    logic [2*COS_W-1:0]          s9_c2_reg [2];
    logic [1:0][SIN_ARG_W-1:0]   s10_arg_reg;
    localparam logic [2*COS_W-1:0] ONE_Q32 = 40'h01_0000_0000;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s9_vld_reg  <= 1'b0;
            s10_vld_reg <= 1'b0;
        end else if (en) begin
            s9_vld_reg  <= s8_vld_reg;
            s10_vld_reg <= s9_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s9_cos_reg  <= s8_cos_reg;
            s10_cos_reg <= s9_cos_reg;
            for (int g = 0; g < 2; g++) begin
                s9_c2_reg[g] <= (2*COS_W)'($signed(s8_cos_reg[g]) * $signed(s8_cos_reg[g]));
                s10_arg_reg[g] <= (s9_c2_reg[g] >= ONE_Q32) ? '0
                                : SIN_ARG_W'(ONE_Q32 - s9_c2_reg[g]);
            end
        end
    end

    // sines
    logic                  sin_vld;
    logic [1:0][SIN_W-1:0] sin_root;
    logic [$bits(sin_side_t)-1:0] sin_side_raw;
    sin_side_t             sin_side;
    sin_side_t             sin_in_side;

    assign sin_in_side.cosv = s10_cos_reg;

    hss_isqrt #(
        .AW    (SIN_ARG_W),
        .LANES (2),
        .SW    ($bits(sin_side_t))
    ) u_sin_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s10_vld_reg),
        .in_arg    (s10_arg_reg),
        .in_side   (sin_in_side),
        .out_valid (sin_vld),
        .out_root  (sin_root),
        .out_side  (sin_side_raw)
    );

    assign sin_side = sin_side_t'(sin_side_raw);

    // stage 11: base products; stage 12: clamped base
    logic                      s11_vld_reg;
    logic signed [2*COS_W-1:0] s11_p1_reg;
    logic [2*SIN_W-1:0]        s11_p2_reg;
    logic [SIN_W-1:0]          s11_stl_reg;
    logic [SIN_W-1:0]          b16_next;

    always_comb begin
        logic signed [2*COS_W:0] base;
        base = {s11_p1_reg[2*COS_W-1], s11_p1_reg}
             + $signed({{(2*COS_W+1-2*SIN_W){1'b0}}, s11_p2_reg});
        if (base[2*COS_W] || base == '0) begin
            b16_next = '0;
        end else if (base[2*COS_W:32] != '0) begin
            b16_next = ONE_Q16;
        end else begin
            b16_next = {1'b0, base[31:16]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s11_vld_reg <= 1'b0;
        end else if (en) begin
            s11_vld_reg <= sin_vld;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s11_p1_reg  <= $signed(sin_side.cosv[0]) * $signed(sin_side.cosv[1]);
            s11_p2_reg  <= (2*SIN_W)'(sin_root[0]) * (2*SIN_W)'(sin_root[1]);
            s11_stl_reg <= sin_root[0];
        end
    end

    // power chain: index 0 is the clamped base, then integer and fractional steps
    logic             pw_vld_reg  [NPW+1];
    logic [SIN_W-1:0] pw_res_reg  [NPW+1];
    logic [SIN_W-1:0] pw_root_reg [NPW+1];
    logic [SIN_W-1:0] pw_stl_reg  [NPW+1];
    logic [SIN_W-1:0] pw_sq_reg   [INT_BITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pw_vld_reg[0] <= 1'b0;
        end else if (en) begin
            pw_vld_reg[0] <= s11_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pw_res_reg[0]  <= ONE_Q16;
            pw_sq_reg[0]   <= b16_next;
            pw_root_reg[0] <= b16_next;
            pw_stl_reg[0]  <= s11_stl_reg;
        end
    end

    for (genvar j = 0; j < INT_BITS; j++) begin : g_int
        logic [2*SIN_W-1:0] rs_prod;
        logic [2*SIN_W-1:0] sq_prod;

        assign rs_prod = (2*SIN_W)'(pw_res_reg[j]) * (2*SIN_W)'(pw_sq_reg[j]);
        assign sq_prod = (2*SIN_W)'(pw_sq_reg[j]) * (2*SIN_W)'(pw_sq_reg[j]);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_vld_reg[j+1] <= 1'b0;
            end else if (en) begin
                pw_vld_reg[j+1] <= pw_vld_reg[j];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pw_res_reg[j+1]  <= shiny_reg[FRAC_BITS+j] ? rs_prod[32:16] : pw_res_reg[j];
                pw_sq_reg[j+1]   <= sq_prod[32:16];
                pw_root_reg[j+1] <= pw_root_reg[j];
                pw_stl_reg[j+1]  <= pw_stl_reg[j];
            end
        end
    end

    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_frac
        localparam int K = INT_BITS + i;
        root_side_t         rt_in_side;
        logic               rt_vld;
        logic [SIN_W-1:0]   rt_root;
        logic [$bits(root_side_t)-1:0] rt_side_raw;
        root_side_t         rt_side;
        logic [2*SIN_W-1:0] rr_prod;

        assign rt_in_side.res = pw_res_reg[K];
        assign rt_in_side.stl = pw_stl_reg[K];

        hss_isqrt #(
            .AW    (SIN_ARG_W),
            .LANES (1),
            .SW    ($bits(root_side_t))
        ) u_root (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (pw_vld_reg[K]),
            .in_arg    ({1'b0, pw_root_reg[K], 16'h0000}),
            .in_side   (rt_in_side),
            .out_valid (rt_vld),
            .out_root  (rt_root),
            .out_side  (rt_side_raw)
        );

        assign rt_side = root_side_t'(rt_side_raw);
        assign rr_prod = (2*SIN_W)'(rt_side.res) * (2*SIN_W)'(rt_root);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pw_vld_reg[K+1] <= 1'b0;
            end else if (en) begin
                pw_vld_reg[K+1] <= rt_vld;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                pw_res_reg[K+1]  <= shiny_reg[FRAC_BITS-1-i] ? rr_prod[32:16] : rt_side.res;
                pw_root_reg[K+1] <= rt_root;
                pw_stl_reg[K+1]  <= rt_side.stl;
            end
        end
    end

    // output stages: colour products, then sum, shift and saturate
    logic                     o1_vld_reg;
    logic [CFG_W+SIN_W-1:0]   o1_pd_reg [3];
    logic [CFG_W+SIN_W-1:0]   o1_ps_reg [3];
    logic                     m_tvalid_reg;
    logic [3*SHADE_W-1:0]     m_shade_reg;
    logic [3*SHADE_W-1:0]     m_shade_next;
    logic [SIN_W-1:0]         spec;

    assign spec = (pw_res_reg[NPW] > ONE_Q16) ? ONE_Q16 : pw_res_reg[NPW];

    always_comb begin
        logic [CFG_W+SIN_W:0] acc;
        for (int c = 0; c < 3; c++) begin
            acc = (CFG_W+SIN_W+1)'(o1_pd_reg[c] >> 3) + (CFG_W+SIN_W+1)'(o1_ps_reg[c]);
            m_shade_next[c*SHADE_W +: SHADE_W] =
                (acc[CFG_W+SIN_W:16] > 18'(OUT_MAX)) ? OUT_MAX : acc[32:16];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o1_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            o1_vld_reg   <= pw_vld_reg[NPW];
            m_tvalid_reg <= o1_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 3; c++) begin
                o1_pd_reg[c] <= (CFG_W+SIN_W)'(diffuse_reg[c]) * (CFG_W+SIN_W)'(pw_stl_reg[NPW]);
                o1_ps_reg[c] <= (CFG_W+SIN_W)'(light_reg[c]) * (CFG_W+SIN_W)'(spec);
            end
            m_shade_reg <= m_shade_next;
        end
    end

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(OUT_DATA_W-3*SHADE_W){1'b0}}, m_shade_reg};

    a_quo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        quo_vld |-> (quo[0] <= ONE_Q14) && (quo[1] <= ONE_Q14) && (quo[2] <= ONE_Q14)
                 && (quo[3] <= ONE_Q14) && (quo[4] <= ONE_Q14) && (quo[5] <= ONE_Q14))
        else $error("normalized component exceeds one");

    a_sin_range: assert property (@(posedge aclk) disable iff (!aresetn)
        sin_vld |-> (sin_root[0] <= ONE_Q16) && (sin_root[1] <= ONE_Q16))
        else $error("sine exceeds one");

    a_pow_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pw_vld_reg[NPW] |-> (pw_res_reg[NPW] <= ONE_Q16) && (pw_root_reg[NPW] <= ONE_Q16))
        else $error("power term exceeds one");

    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(o1_vld_reg) && $stable(s1_vld_reg)
                                 && $stable(pw_vld_reg[0]))
        else $error("pipeline advanced during stall");

endmodule
`default_nettype wire
